// ===== rtl/trca_pkg.sv =====
// Shared types, constants and helpers of the transmit rate credit adaptation block.
package trca_pkg;
	localparam int DEST_COUNT_DEF = 64;
	localparam int MAX_RATES = 32;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int RATE_W = 5;
	localparam int CRED_W = 4;
	localparam int RETRY_IN_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] OP_FEEDBACK = 2'd0;
	localparam logic [1:0] OP_ADJUST = 2'd1;
	localparam logic [1:0] OP_REQUEST = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ALT_FAIL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CREDITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERCENT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd3;

	localparam logic [CRED_W-1:0] CRED_MAX = 4'd15;
	localparam logic [CRED_W-1:0] CREDITS_RESET = 4'd10;
	localparam logic [6:0] PERCENT_RESET = 7'd10;
	localparam logic [7:0] MIN_SAMPLES_RESET = 8'd10;
	localparam logic [2:0] FAIL_RETRY_ADD = 3'd4;

	typedef struct packed {
		logic       alt_fail;
		logic [3:0] credits_to_raise;
		logic [6:0] percent;
		logic [7:0] min_samples;
	} cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate0;
		logic [RATE_W-1:0] rate1;
		logic [RATE_W-1:0] rate2;
		logic [RATE_W-1:0] rate3;
		logic [2:0]        tries0;
		logic [1:0]        tries1;
		logic [1:0]        tries2;
		logic [1:0]        tries3;
		logic              known;
		logic [CRED_W-1:0] credit;
	} result_t;

	function automatic result_t make_result(input logic show, input logic [RATE_W-1:0] idx,
		input logic known, input logic [CRED_W-1:0] cred);
		result_t r;
		r = '0;
		if (show) begin
			r.rate0 = idx;
			r.tries0 = 3'd4;
			if (idx >= RATE_W'(1)) begin
				r.rate1 = idx - RATE_W'(1);
				r.tries1 = 2'd2;
			end
			if (idx >= RATE_W'(2)) begin
				r.rate2 = idx - RATE_W'(2);
				r.tries2 = 2'd2;
			end
			if (idx >= RATE_W'(3)) begin
				r.rate3 = idx - RATE_W'(3);
				r.tries3 = 2'd2;
			end
		end
		r.known = known;
		r.credit = known ? cred : '0;
		return r;
	endfunction
endpackage

// ===== rtl/tx_rate_credit_adaptation.sv =====
// Top level of the transmit rate credit adaptation block.
//  channel | direction | handshake          | contents
//  in      | input     | in_valid/in_ready  | operation and destination word
//  out     | output    | out_valid/out_ready| rate chain, credit and entry status
//  cfg     | input     | cfg_we             | register index and data
// With the back part idle, an accepted word is read from the table into rd_s1 and then
// written to the result register. The back part takes a new word only once the last
// result is taken: the table read, the read-modify-write stage and the result handshake.
// A held result stops the back part; the two-entry queue then fills and in_ready drops.
// Reset clears all entries at once through valid flags; no clearing pass is needed.
module tx_rate_credit_adaptation #(
	parameter int DEST_COUNT = trca_pkg::DEST_COUNT_DEF,
	parameter int COUNT_WIDTH = trca_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [5:0] dest_index,
	input  logic       tx_failed,
	input  logic       alt_used,
	input  logic [3:0] retry_count,
	input  logic [4:0] sent_rate_index,
	input  logic       group_dest,
	input  logic [5:0] rate_count,
	input  logic [4:0] start_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] rate0_index,
	output logic [4:0] rate1_index,
	output logic [4:0] rate2_index,
	output logic [4:0] rate3_index,
	output logic [2:0] tries0,
	output logic [1:0] tries1,
	output logic [1:0] tries2,
	output logic [1:0] tries3,
	output logic       entry_known,
	output logic [3:0] credit_level,
	input  logic       cfg_we,
	input  logic [trca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trca_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = (DEST_COUNT > 1) ? $clog2(DEST_COUNT) : 1;
	localparam int DEST_SPAN = 64;

	trca_pkg::cfg_t cfg_q;
	trca_pkg::result_t res;
	logic [AW-1:0] dest;
	logic [AW-1:0] dest_map [DEST_SPAN];
	logic q_valid, q_pop, q_fail, q_alt, q_group;
	logic [1:0] q_op;
	logic [AW-1:0] q_dest;
	logic [3:0] q_retry;
	logic [4:0] q_sent, q_start;
	logic [5:0] q_cnt;

	// Destination numbers wrap onto the table through a constant map.
	for (genvar g = 0; g < DEST_SPAN; g++) begin : g_dest_map
		assign dest_map[g] = AW'(g % DEST_COUNT);
	end

	assign dest = dest_map[dest_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alt_fail <= 1'b0;
			cfg_q.credits_to_raise <= trca_pkg::CREDITS_RESET;
			cfg_q.percent <= trca_pkg::PERCENT_RESET;
			cfg_q.min_samples <= trca_pkg::MIN_SAMPLES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				trca_pkg::REG_ALT_FAIL: cfg_q.alt_fail <= cfg_data[0];
				trca_pkg::REG_CREDITS: cfg_q.credits_to_raise <= cfg_data[3:0];
				trca_pkg::REG_PERCENT: cfg_q.percent <= cfg_data[6:0];
				trca_pkg::REG_MIN_SAMPLES: cfg_q.min_samples <= cfg_data;
				default: ;
			endcase
		end
	end

	trca_front #(.AW(AW)) u_front (
		.clk, .arst_n, .valid(in_valid), .ready(in_ready), .operation, .dest,
		.tx_failed, .alt_used, .retry_count, .sent_rate_index, .group_dest,
		.rate_count, .start_index, .q_valid, .q_pop, .q_op, .q_dest, .q_fail,
		.q_alt, .q_retry, .q_sent, .q_group, .q_cnt, .q_start
	);

	trca_back #(.AW(AW), .DEST_COUNT(DEST_COUNT), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_pop, .q_op, .q_dest, .q_fail,
		.q_alt, .q_retry, .q_sent, .q_group, .q_cnt, .q_start, .out_valid,
		.out_ready, .result(res)
	);

	assign rate0_index = res.rate0;
	assign rate1_index = res.rate1;
	assign rate2_index = res.rate2;
	assign rate3_index = res.rate3;
	assign tries0 = res.tries0;
	assign tries1 = res.tries1;
	assign tries2 = res.tries2;
	assign tries3 = res.tries3;
	assign entry_known = res.known;
	assign credit_level = res.credit;
endmodule

// ===== rtl/trca_front.sv =====
// Front part: accepts words and queues them, undecoded, for the back part.
module trca_front #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          ready,
	input  logic [1:0]    operation,
	input  logic [AW-1:0] dest,
	input  logic          tx_failed,
	input  logic          alt_used,
	input  logic [3:0]    retry_count,
	input  logic [4:0]    sent_rate_index,
	input  logic          group_dest,
	input  logic [5:0]    rate_count,
	input  logic [4:0]    start_index,
	output logic          q_valid,
	input  logic          q_pop,
	output logic [1:0]    q_op,
	output logic [AW-1:0] q_dest,
	output logic          q_fail,
	output logic          q_alt,
	output logic [3:0]    q_retry,
	output logic [4:0]    q_sent,
	output logic          q_group,
	output logic [5:0]    q_cnt,
	output logic [4:0]    q_start
);
	localparam int W = 2 + AW + 1 + 1 + 4 + 5 + 1 + 6 + 5;
	logic [W-1:0] mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign ready = (cnt_q != 2'd2);
	assign push = valid && ready;
	assign q_valid = (cnt_q != 2'd0);
	assign {q_op, q_dest, q_fail, q_alt, q_retry, q_sent, q_group, q_cnt, q_start} = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= {operation, dest, tx_failed, alt_used, retry_count,
			sent_rate_index, group_dest, rate_count, start_index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> !ready)
		else $error("ready while full");
`endif
endmodule

// ===== rtl/trca_back.sv =====
// Back part: two-stage read-modify-write of the destination table and result register.
module trca_back #(
	parameter int AW = 6,
	parameter int DEST_COUNT = 64,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  trca_pkg::cfg_t      cfg,
	input  logic                q_valid,
	output logic                q_pop,
	input  logic [1:0]          q_op,
	input  logic [AW-1:0]       q_dest,
	input  logic                q_fail,
	input  logic                q_alt,
	input  logic [3:0]          q_retry,
	input  logic [4:0]          q_sent,
	input  logic                q_group,
	input  logic [5:0]          q_cnt,
	input  logic [4:0]          q_start,
	output logic                out_valid,
	input  logic                out_ready,
	output trca_pkg::result_t   result
);
	localparam int CW = COUNT_WIDTH;
	localparam int RW = COUNT_WIDTH + 4;
	localparam int EW = 5 + 5 + 4 + CW + CW + RW;
	localparam int HI_MAX = trca_pkg::MAX_RATES - 1;

	logic [EW-1:0] mem_q [DEST_COUNT];
	logic [DEST_COUNT-1:0] valid_q;

	logic busy_s1, out_valid_q;
	logic [1:0] op_s1;
	logic [AW-1:0] dest_s1;
	logic fail_s1, alt_s1, group_s1, known_s1;
	logic [3:0] retry_s1;
	logic [4:0] sent_s1, start_s1;
	logic [5:0] cnt_s1;
	logic [EW-1:0] rd_s1;
	trca_pkg::result_t res_q;

	logic [4:0] cur, hi, n_cur, n_hi, st;
	logic [3:0] cr, n_cr;
	logic [CW-1:0] sc, fc, n_sc, n_fc;
	logic [RW-1:0] rt, n_rt;
	logic n_known, wr;
	logic enough, down, up;
	logic [CW+6:0] prod;
	logic [CW+11:0] lim;
	logic [5:0] cm1;

	// Items enter only when the result register is free, so one is in flight at a time.
	assign q_pop = q_valid && !busy_s1 && !out_valid_q;
	assign out_valid = out_valid_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (q_pop) rd_s1 <= mem_q[q_dest];
		if (wr) mem_q[dest_s1] <= {n_cur, n_hi, n_cr, n_sc, n_fc, n_rt};
	end

	// Retries stay below percent of successes over 100 exactly when
	// 100 * (retries + 1) is at most successes times percent.
	always_comb begin
		{cur, hi, cr, sc, fc, rt} = rd_s1;
		n_cur = cur; n_hi = hi; n_cr = cr; n_sc = sc; n_fc = fc; n_rt = rt;
		n_known = known_s1;
		wr = 1'b0;
		enough = ({1'b0, sc} + {1'b0, fc}) > (CW+1)'(cfg.min_samples);
		prod = (CW+7)'(sc) * (CW+7)'(cfg.percent);
		lim = ((CW+12)'(rt) + (CW+12)'(1)) * (CW+12)'(100);
		down = ((fc != '0) && (sc == '0)) || (enough && ({4'd0, sc} < rt));
		up = enough && (fc == '0) && (lim <= (CW+12)'(prod));
		cm1 = (cnt_s1 == 6'd0) ? 6'd0 : cnt_s1 - 6'd1;
		n_hi = (cm1 > 6'(HI_MAX)) ? 5'(HI_MAX) : cm1[4:0];
		st = (start_s1 > n_hi) ? n_hi : start_s1;
		if (!busy_s1) begin
			n_hi = hi;
		end else if (op_s1 == trca_pkg::OP_FEEDBACK) begin
			if (known_s1 && cur == sent_s1) begin
				wr = 1'b1;
				if (!fail_s1 && (!cfg.alt_fail || !alt_s1)) begin
					n_sc = (sc == '1) ? sc : sc + CW'(1);
					n_rt = ((RW+1)'(rt) + (RW+1)'(retry_s1) > (RW+1)'({RW{1'b1}}))
						? '1 : rt + RW'(retry_s1);
				end else begin
					n_fc = (fc == '1) ? fc : fc + CW'(1);
					n_rt = ((RW+1)'(rt) + (RW+1)'(trca_pkg::FAIL_RETRY_ADD)
						> (RW+1)'({RW{1'b1}})) ? '1 : rt + RW'(trca_pkg::FAIL_RETRY_ADD);
				end
			end
			n_hi = hi;
		end else if (op_s1 == trca_pkg::OP_ADJUST) begin
			n_hi = hi;
			if (known_s1) begin
				wr = 1'b1;
				if (down) begin
					if (cur != '0) n_cur = cur - 5'd1;
					n_cr = '0;
				end else if (up) begin
					n_cr = (cr == trca_pkg::CRED_MAX) ? cr : cr + 4'd1;
					if (n_cr >= cfg.credits_to_raise) begin
						if (cur < hi) n_cur = cur + 5'd1;
						n_cr = '0;
					end
				end else if (enough && cr != '0) begin
					n_cr = cr - 4'd1;
				end
				n_sc = '0; n_fc = '0; n_rt = '0;
			end
		end else if (op_s1 == trca_pkg::OP_REQUEST && !group_s1 && !known_s1) begin
			wr = 1'b1;
			n_known = 1'b1;
			n_cur = st;
			n_cr = '0; n_sc = '0; n_fc = '0; n_rt = '0;
		end else begin
			n_hi = hi;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_op; dest_s1 <= q_dest; fail_s1 <= q_fail; alt_s1 <= q_alt;
			retry_s1 <= q_retry; sent_s1 <= q_sent; group_s1 <= q_group;
			cnt_s1 <= q_cnt; start_s1 <= q_start; known_s1 <= valid_q[q_dest];
		end
		if (busy_s1) begin
			res_q <= trca_pkg::make_result(
				(op_s1 == trca_pkg::OP_REQUEST && group_s1) || n_known,
				(op_s1 == trca_pkg::OP_REQUEST && group_s1) ? 5'd0 : n_cur,
				n_known, n_cr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			busy_s1 <= q_pop;
			if (wr) valid_q[dest_s1] <= 1'b1;
			if (busy_s1) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !out_valid_q)
		else $error("result overwritten");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> out_valid_q)
		else $error("result missing");
	a_create_known: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_s1 && wr) |=> valid_q[$past(dest_s1)])
		else $error("entry not marked valid");
`endif
endmodule

// ===== test/tx_rate_credit_adaptation_checker.sv =====
// Checker of the transmit rate credit adaptation block: prediction and comparison of result words.
module tx_rate_credit_adaptation_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [5:0]  dest_index,
	input  logic        tx_failed,
	input  logic        alt_used,
	input  logic [3:0]  retry_count,
	input  logic [4:0]  sent_rate_index,
	input  logic        group_dest,
	input  logic [5:0]  rate_count,
	input  logic [4:0]  start_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  trca_pkg::result_t actual,
	input  logic        cfg_we,
	input  logic [trca_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trca_pkg::CFG_DATA_W-1:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int CNT_MAX = 65535;
	localparam int RETRY_MAX = (1 << 20) - 1;

	logic       known [64];
	logic [4:0] cur [64];
	logic [4:0] top_rate [64];
	int         cred [64];
	int         succ [64];
	int         fails [64];
	int         retries [64];
	logic       alt_fail;
	int         raise_at;
	int         percent;
	int         min_samp;
	trca_pkg::result_t expected_q[$];

	function automatic int sat(input int a, input int b, input int lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	function automatic trca_pkg::result_t chain(input logic [4:0] idx, input logic k,
		input int c);
		trca_pkg::result_t r;
		r = '0;
		r.rate0 = idx;
		r.tries0 = 3'd4;
		if (idx >= 1) begin r.rate1 = idx - 5'd1; r.tries1 = 2'd2; end
		if (idx >= 2) begin r.rate2 = idx - 5'd2; r.tries2 = 2'd2; end
		if (idx >= 3) begin r.rate3 = idx - 5'd3; r.tries3 = 2'd2; end
		r.known = k;
		r.credit = k ? 4'(c) : 4'd0;
		return r;
	endfunction

	task automatic adjust_rate(input int d);
		int s, f, r;
		logic enough, down, up;
		s = succ[d];
		f = fails[d];
		r = retries[d];
		enough = (s + f) > min_samp;
		down = (f > 0 && s == 0) || (enough && s < r);
		up = enough && f == 0 && r < (longint'(s) * percent) / 100;
		if (down) begin
			if (cur[d] > 0) cur[d]--;
			cred[d] = 0;
		end else if (up) begin
			if (cred[d] < 15) cred[d]++;
			if (cred[d] >= raise_at) begin
				if (cur[d] < top_rate[d]) cur[d]++;
				cred[d] = 0;
			end
		end else if (enough && cred[d] > 0) begin
			cred[d]--;
		end
		succ[d] = 0;
		fails[d] = 0;
		retries[d] = 0;
	endtask

	task automatic predict_word();
		int d, hi, st;
		trca_pkg::result_t r;
		d = dest_index;
		if (operation == trca_pkg::OP_FEEDBACK) begin
			if (known[d] && cur[d] == sent_rate_index) begin
				if (!tx_failed && (!alt_fail || !alt_used)) begin
					succ[d] = sat(succ[d], 1, CNT_MAX);
					retries[d] = sat(retries[d], retry_count, RETRY_MAX);
				end else begin
					fails[d] = sat(fails[d], 1, CNT_MAX);
					retries[d] = sat(retries[d], 4, RETRY_MAX);
				end
			end
		end else if (operation == trca_pkg::OP_ADJUST) begin
			if (known[d]) adjust_rate(d);
		end else if (operation == trca_pkg::OP_REQUEST && !group_dest && !known[d]) begin
			hi = (rate_count == 0) ? 0 : rate_count - 1;
			if (hi > 31) hi = 31;
			st = (start_index > hi) ? hi : start_index;
			known[d] = 1'b1;
			top_rate[d] = 5'(hi);
			cur[d] = 5'(st);
			cred[d] = 0;
			succ[d] = 0;
			fails[d] = 0;
			retries[d] = 0;
		end
		if (operation == trca_pkg::OP_REQUEST && group_dest) r = chain(5'd0, known[d], cred[d]);
		else if (known[d]) r = chain(cur[d], 1'b1, cred[d]);
		else r = '0;
		expected_q = {expected_q, r};
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		trca_pkg::result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) known[i] = 1'b0;
			alt_fail = 1'b0;
			raise_at = 10;
			percent = 10;
			min_samp = 10;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					trca_pkg::REG_ALT_FAIL: alt_fail = cfg_data[0];
					trca_pkg::REG_CREDITS: raise_at = cfg_data[3:0];
					trca_pkg::REG_PERCENT: percent = cfg_data[6:0];
					trca_pkg::REG_MIN_SAMPLES: min_samp = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) predict_word();
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result word with no expectation waiting");
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					check_field("rate0_index", e.rate0, actual.rate0);
					check_field("rate1_index", e.rate1, actual.rate1);
					check_field("rate2_index", e.rate2, actual.rate2);
					check_field("rate3_index", e.rate3, actual.rate3);
					check_field("tries0", e.tries0, actual.tries0);
					check_field("tries1", e.tries1, actual.tries1);
					check_field("tries2", e.tries2, actual.tries2);
					check_field("tries3", e.tries3, actual.tries3);
					check_field("entry_known", e.known, actual.known);
					check_field("credit_level", e.credit, actual.credit);
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// ===== test/tx_rate_credit_adaptation_test.sv =====
// Testbench top of the transmit rate credit adaptation block: stimulus, idling and verdict.
module tx_rate_credit_adaptation_test;
	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = '0;
	logic [5:0] dest_index = '0;
	logic       tx_failed = 1'b0;
	logic       alt_used = 1'b0;
	logic [3:0] retry_count = '0;
	logic [4:0] sent_rate_index = '0;
	logic       group_dest = 1'b0;
	logic [5:0] rate_count = 6'd1;
	logic [4:0] start_index = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [4:0] rate0_index, rate1_index, rate2_index, rate3_index;
	logic [2:0] tries0;
	logic [1:0] tries1, tries2, tries3;
	logic       entry_known;
	logic [3:0] credit_level;
	trca_pkg::result_t actual;
	logic       cfg_we = 1'b0;
	logic [trca_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [trca_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	logic       quiet = 1'b0;
	logic       hold_off = 1'b0;
	logic       hold_done = 1'b0;
	logic [4:0] rate_seen [64];
	logic [6:0] track_q [$];

	always #5 clk = ~clk;

	assign actual = {rate0_index, rate1_index, rate2_index, rate3_index, tries0, tries1,
		tries2, tries3, entry_known, credit_level};

	tx_rate_credit_adaptation u_top (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .dest_index, .tx_failed,
		.alt_used, .retry_count, .sent_rate_index, .group_dest, .rate_count,
		.start_index, .out_valid, .out_ready,
		.rate0_index, .rate1_index, .rate2_index, .rate3_index,
		.tries0, .tries1, .tries2, .tries3, .entry_known, .credit_level,
		.cfg_we, .cfg_index, .cfg_data
	);

	tx_rate_credit_adaptation_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .dest_index, .tx_failed,
		.alt_used, .retry_count, .sent_rate_index, .group_dest, .rate_count,
		.start_index, .out_valid, .out_ready, .actual, .cfg_we, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	// Receiver: random stall bursts, one long hold-off on request, none when quiet.
	always begin
		int n;
		@(posedge clk);
		if (hold_off && !hold_done) begin
			out_ready <= 1'b0;
			repeat (60) @(posedge clk);
			hold_done = 1'b1;
		end else if (!quiet && $urandom_range(3) == 0) begin
			n = $urandom_range(11, 1);
			out_ready <= 1'b0;
			repeat (n - 1) @(posedge clk);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("tx_rate_credit_adaptation_test NOT OK");
			$finish;
		end
	end

	// Keeps feedback on the destination's current rate most of the time.
	always @(posedge clk) begin
		logic [6:0] t;
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) rate_seen[i] <= 5'($urandom);
		end else begin
			if (in_valid && in_ready) begin
				t = {operation == trca_pkg::OP_REQUEST && group_dest, dest_index};
				track_q = {track_q, t};
			end
			if (out_valid && out_ready && track_q.size() != 0) begin
				t = track_q.pop_front();
				if (!t[6] && entry_known) rate_seen[t[5:0]] <= rate0_index;
			end
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [5:0] d, input logic f,
		input logic alt, input logic [3:0] rc, input logic [4:0] sr, input logic g,
		input logic [5:0] cnt, input logic [4:0] st);
		int n;
		if (!quiet && $urandom_range(4) == 0) begin
			n = $urandom_range(11, 1);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		dest_index <= d;
		tx_failed <= f;
		alt_used <= alt;
		retry_count <= rc;
		sent_rate_index <= sr;
		group_dest <= g;
		rate_count <= cnt;
		start_index <= st;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [trca_pkg::CFG_IDX_W-1:0] idx,
		input logic [trca_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word(input int dest_span);
		logic [5:0] d;
		int kind;
		d = 6'($urandom_range(dest_span));
		kind = $urandom_range(99);
		if (kind < 70)
			send_word(trca_pkg::OP_FEEDBACK, d, $urandom_range(5) == 0,
				1'($urandom_range(1)), 4'($urandom),
				($urandom_range(9) == 0) ? 5'($urandom) : rate_seen[d],
				1'($urandom_range(1)), 6'($urandom), 5'($urandom));
		else if (kind < 85)
			send_word(trca_pkg::OP_ADJUST, d, 1'($urandom_range(1)),
				1'($urandom_range(1)), 4'($urandom), 5'($urandom),
				1'($urandom_range(1)), 6'($urandom), 5'($urandom));
		else if (kind < 98)
			send_word(trca_pkg::OP_REQUEST, d, 1'($urandom_range(1)),
				1'($urandom_range(1)), 4'($urandom), 5'($urandom),
				$urandom_range(4) == 0, 6'($urandom), 5'($urandom));
		else
			send_word(trca_pkg::OP_RESERVED, d, 1'($urandom_range(1)),
				1'($urandom_range(1)), 4'($urandom), 5'($urandom),
				1'($urandom_range(1)), 6'($urandom), 5'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed words.
		send_word(trca_pkg::OP_FEEDBACK, 6'd5, 1'b0, 1'b0, 4'd3, 5'd0, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_ADJUST, 6'd5, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_REQUEST, 6'd63, 1'b0, 1'b0, 4'd0, 5'd0, 1'b1, 6'd32, 5'd31);
		send_word(trca_pkg::OP_REQUEST, 6'd0, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd0, 5'd31);
		send_word(trca_pkg::OP_REQUEST, 6'd1, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd63, 5'd31);
		send_word(trca_pkg::OP_REQUEST, 6'd2, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd4, 5'd2);
		send_word(trca_pkg::OP_REQUEST, 6'd1, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_FEEDBACK, 6'd1, 1'b0, 1'b0, 4'd15, 5'd30, 1'b0, 6'd1, 5'd0);
		for (int i = 0; i < 12; i++)
			send_word(trca_pkg::OP_FEEDBACK, 6'd1, 1'b0, 1'b0, 4'd0, 5'd31, 1'b0, 6'd1,
				5'd0);
		send_word(trca_pkg::OP_ADJUST, 6'd1, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_FEEDBACK, 6'd2, 1'b1, 1'b1, 4'd15, 5'd2, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_ADJUST, 6'd2, 1'b0, 1'b0, 4'd0, 5'd0, 1'b0, 6'd1, 5'd0);
		send_word(trca_pkg::OP_RESERVED, 6'd2, 1'b1, 1'b1, 4'd15, 5'd31, 1'b1, 6'd63, 5'd31);
		drain();
		// Settings per phase, extremes included; even phases send random words to
		// destinations 0 to 7 and odd phases to all 64, so the credits and step-ups are reached.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(trca_pkg::REG_ALT_FAIL, 8'd1);
					write_reg(trca_pkg::REG_CREDITS, 8'd1);
					write_reg(trca_pkg::REG_PERCENT, 8'd100);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd0); end
				1: begin write_reg(trca_pkg::REG_ALT_FAIL, 8'd0);
					write_reg(trca_pkg::REG_CREDITS, 8'd15);
					write_reg(trca_pkg::REG_PERCENT, 8'd0);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd255); end
				2: begin write_reg(trca_pkg::REG_CREDITS, 8'd0);
					write_reg(trca_pkg::REG_PERCENT, 8'd127);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd2); end
				3: begin write_reg(trca_pkg::REG_ALT_FAIL, 8'd1);
					write_reg(trca_pkg::REG_CREDITS, 8'd2);
					write_reg(trca_pkg::REG_PERCENT, 8'd50);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd3); end
				4: begin write_reg(trca_pkg::REG_ALT_FAIL, 8'hFE);
					write_reg(trca_pkg::REG_CREDITS, 8'hF3);
					write_reg(trca_pkg::REG_PERCENT, 8'h80 | 8'd40);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd1); end
				default: begin write_reg(trca_pkg::REG_CREDITS, 8'd10);
					write_reg(trca_pkg::REG_PERCENT, 8'd10);
					write_reg(trca_pkg::REG_MIN_SAMPLES, 8'd10); end
			endcase
			if (ph == 2) hold_off = 1'b1;
			if (ph == 5) quiet = 1'b1;
			for (int i = 0; i < 180; i++) random_word(ph[0] ? 63 : 7);
			drain();
		end
		if (fail_count == 0) $display("tx_rate_credit_adaptation_test OK");
		else $display("tx_rate_credit_adaptation_test NOT OK");
		$finish;
	end
endmodule
